// ----- hdl/svsm_pkg.sv -----
// Package for the sampled value stream monitor.
// Types, field positions and finding bit codes. No dependencies.
package svsm_pkg;

  localparam int unsigned FindIdent    = 0;
  localparam int unsigned FindPub      = 1;
  localparam int unsigned FindDup      = 2;
  localparam int unsigned FindDiscont  = 3;
  localparam int unsigned FindAttrBase = 4;
  localparam int unsigned FindIval     = 10;
  localparam int unsigned FindRate     = 11;
  localparam int unsigned FindMeas     = 12;

  localparam logic [1:0] RegModulus = 2'd0;
  localparam logic [1:0] RegIval    = 2'd1;
  localparam logic [1:0] RegTol     = 2'd2;
  localparam logic [1:0] RegRate    = 2'd3;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_MEAS,
    KIND_IDENT
  } kind_e;

  // classified item passed from front end to back end
  typedef struct packed {
    kind_e        kind;
    logic [11:0]  stream_slot;
    logic [11:0]  logical_slot;
    logic [47:0]  source_mac;
    logic [15:0]  smp_cnt;
    logic         reordered;
    logic [47:0]  time_us;
    logic [7:0]   present;
    logic [31:0]  config_revision;
    logic [35:0]  sync_rate_vlan;
    logic [31:0]  quality;
    logic [31:0]  dataset_tag;
  } item_t;

  typedef struct packed {
    logic [16:0] modulus;
    logic [19:0] ival;
    logic [19:0] tol;
    logic [15:0] rate;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_MOD,
    ST_CHECK,
    ST_WRITE
  } bk_state_e;

endpackage

// ----- hdl/svsm_front.sv -----
// Front end: accepts items, drops those that give no result, classifies the
// rest and pushes them into a two entry queue. Depends on svsm_pkg.
module svsm_front #(
  parameter int unsigned STREAM_ENTRIES      = 64,
  parameter int unsigned LOGICAL_ENTRIES     = 64,
  parameter int unsigned MEASUREMENT_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                func_i,
  input  logic [5:0]          stream_slot_i,
  input  logic [5:0]          logical_slot_i,
  input  logic [47:0]         source_mac_i,
  input  logic [15:0]         smp_cnt_i,
  input  logic                reordered_i,
  input  logic [47:0]         time_us_i,
  input  logic [7:0]          attribute_present_i,
  input  logic [31:0]         config_revision_i,
  input  logic [35:0]         sync_rate_vlan_i,
  input  logic [31:0]         quality_i,
  input  logic [31:0]         dataset_tag_i,
  output logic                q_valid_o,
  output svsm_pkg::item_t     q_item_o,
  input  logic                q_pop_i,
  output logic                empty_o
);
  import svsm_pkg::*;

  item_t       fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        take, keep, push;
  item_t       it;

  assign busy_o = (cnt_q == 2'd2);
  assign take   = start_i && !busy_o;
  assign empty_o = (cnt_q == 2'd0);

  always_comb begin
    it = '0;
    it.stream_slot     = {6'd0, stream_slot_i};
    it.logical_slot    = {6'd0, logical_slot_i};
    it.source_mac      = source_mac_i;
    it.smp_cnt         = smp_cnt_i;
    it.reordered       = reordered_i;
    it.time_us         = time_us_i;
    it.present         = attribute_present_i;
    it.config_revision = config_revision_i;
    it.sync_rate_vlan  = sync_rate_vlan_i;
    it.quality         = quality_i;
    it.dataset_tag     = dataset_tag_i;
    keep = 1'b0;
    it.kind = KIND_SAMPLE;
    if (func_i) begin
      it.kind = KIND_MEAS;
      keep = attribute_present_i[6] &&
             ({26'd0, stream_slot_i} < 32'(MEASUREMENT_ENTRIES));
    end else if (attribute_present_i[1]) begin
      if (!attribute_present_i[0]) begin
        it.kind = KIND_IDENT;
        keep = 1'b1;
      end else begin
        keep = ({26'd0, stream_slot_i} < 32'(STREAM_ENTRIES)) &&
               ({26'd0, logical_slot_i} < 32'(LOGICAL_ENTRIES));
      end
    end
  end

  assign push = take && keep;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= it;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = fifo_q[rd_ptr_q];
endmodule

// ----- hdl/svsm_back.sv -----
// Back end: per-stream tables and check sequencer, one result per item.
// Depends on svsm_pkg.
module svsm_back #(
  parameter int unsigned STREAM_ENTRIES      = 64,
  parameter int unsigned LOGICAL_ENTRIES     = 64,
  parameter int unsigned MEASUREMENT_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  svsm_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  svsm_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  output logic                idle_o,
  output logic                done_o,
  output logic [12:0]         finding_mask_o,
  output logic [16:0]         expected_count_o,
  output logic signed [48:0]  interval_us_o
);
  import svsm_pkg::*;

  localparam int unsigned SW = (STREAM_ENTRIES > 1) ? $clog2(STREAM_ENTRIES) : 1;
  localparam int unsigned LW = (LOGICAL_ENTRIES > 1) ? $clog2(LOGICAL_ENTRIES) : 1;
  localparam int unsigned MW =
    (MEASUREMENT_ENTRIES > 1) ? $clog2(MEASUREMENT_ENTRIES) : 1;
  // remainder steps: 20 dividend bits, four bits per cycle
  localparam int unsigned ModSteps = 5;

  // stream entry: count, time, config revision, srv, quality, dataset, present
  localparam int unsigned EW = 16 + 48 + 32 + 36 + 32 + 32 + 8;

  logic [EW-1:0] smem [STREAM_ENTRIES];
  logic [47:0]   lmem [LOGICAL_ENTRIES];
  logic [31:0]   mmem [MEASUREMENT_ENTRIES];
  logic [STREAM_ENTRIES-1:0]      sval_q;
  logic [LOGICAL_ENTRIES-1:0]     lval_q;
  logic [MEASUREMENT_ENTRIES-1:0] mval_q;

  bk_state_e     state_q, state_d;
  item_t         it_q;
  logic [EW-1:0] srd_q;
  logic [47:0]   lrd_q;
  logic [31:0]   mrd_q;
  logic          sv_q, lv_q, mv_q;
  logic [16:0]   next_q;
  logic signed [48:0] dt_q;
  logic [12:0]   mask_q;
  logic [19:0]   mdiv_q, mdiv_d;
  logic [16:0]   mrem_q, mrem_d;
  logic [2:0]    mstep_q;
  logic [17:0]   mtry;

  logic [SW-1:0] sidx;
  logic [LW-1:0] lidx;
  logic [MW-1:0] midx;
  assign sidx = it_q.stream_slot[SW-1:0];
  assign lidx = it_q.logical_slot[LW-1:0];
  assign midx = it_q.stream_slot[MW-1:0];

  logic [15:0] o_cnt;
  logic [47:0] o_time;
  logic [31:0] o_cr, o_q, o_ds;
  logic [35:0] o_srv;
  logic [7:0]  o_pres;
  assign {o_cnt, o_time, o_cr, o_srv, o_q, o_ds, o_pres} = srd_q;

  logic [16:0] inc;
  logic        wr_en;
  logic [12:0] chk, pre_mask, res_mask;
  logic [16:0] res_expc;
  logic signed [48:0] res_ivl;
  logic signed [49:0] dev;
  logic [49:0] adev;
  logic [5:0]  neq;
  logic [7:0]  both;

  assign inc = {1'b0, o_cnt} + 17'd1;

  // old+1 modulo the wrap value: restoring remainder, four steps per cycle
  always_comb begin
    mrem_d = mrem_q;
    mdiv_d = mdiv_q;
    mtry   = '0;
    for (int j = 0; j < 4; j++) begin
      mtry   = {mrem_d, mdiv_d[19]};
      mdiv_d = {mdiv_d[18:0], 1'b0};
      if (mtry >= {1'b0, cfg_i.modulus}) mtry = mtry - {1'b0, cfg_i.modulus};
      mrem_d = mtry[16:0];
    end
  end

  always_comb begin
    both = it_q.present & o_pres;
    neq[0] = it_q.config_revision != o_cr;
    neq[1] = it_q.sync_rate_vlan[35:28] != o_srv[35:28];
    neq[2] = it_q.sync_rate_vlan[15:0] != o_srv[15:0];
    neq[3] = it_q.sync_rate_vlan[27:16] != o_srv[27:16];
    neq[4] = it_q.quality != o_q;
    neq[5] = it_q.dataset_tag != o_ds;
    dev  = {dt_q[48], dt_q} - $signed({30'd0, cfg_i.ival});
    adev = dev[49] ? 50'(-dev) : 50'(dev);
    chk = mask_q;
    if (sv_q && !it_q.reordered) begin
      if ({1'b0, it_q.smp_cnt} != next_q)
        chk[(it_q.smp_cnt == srd_q[EW-1 -: 16]) ? FindDup : FindDiscont] = 1'b1;
      for (int k = 0; k < 6; k++)
        if (both[2+k] && neq[k]) chk[FindAttrBase+k] = 1'b1;
      if (cfg_i.ival != 20'd0 && !dt_q[48] && adev > {30'd0, cfg_i.tol})
        chk[FindIval] = 1'b1;
    end
  end

  always_comb begin
    pre_mask = '0;
    if (lv_q && lrd_q != it_q.source_mac) pre_mask[FindPub] = 1'b1;
    if (cfg_i.rate != 16'd0 && it_q.present[4] &&
        it_q.sync_rate_vlan[15:0] != cfg_i.rate) pre_mask[FindRate] = 1'b1;
    res_mask = '0;
    res_expc = '0;
    res_ivl  = '0;
    case (it_q.kind)
      KIND_IDENT: res_mask[FindIdent] = 1'b1;
      KIND_MEAS:  res_mask[FindMeas]  = mv_q && (mrd_q != it_q.quality);
      default: begin
        res_mask = chk;
        if (sv_q) begin
          res_expc = next_q;
          res_ivl  = dt_q;
        end
      end
    endcase
  end

  assign wr_en = (state_q == ST_WRITE);

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      ST_IDLE:  if (q_valid_i) begin
        state_d = ST_READ;
        q_pop_o = 1'b1;
      end
      ST_READ:  state_d = ST_CALC;
      ST_CALC:  state_d = ST_MOD;
      ST_MOD:   if (mstep_q == 3'(ModSteps - 1)) state_d = ST_CHECK;
      ST_CHECK: state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sval_q  <= '0;
      lval_q  <= '0;
      mval_q  <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= wr_en;
      if (wr_en) begin
        case (it_q.kind)
          KIND_MEAS: mval_q[midx] <= 1'b1;
          KIND_SAMPLE: begin
            lval_q[lidx] <= 1'b1;
            if (!it_q.reordered) sval_q[sidx] <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) it_q <= q_item_i;
    if (state_q == ST_READ) begin
      srd_q <= smem[sidx];
      lrd_q <= lmem[lidx];
      mrd_q <= mmem[midx];
      sv_q  <= sval_q[sidx];
      lv_q  <= lval_q[lidx];
      mv_q  <= mval_q[midx];
    end
    if (state_q == ST_CALC) begin
      next_q  <= inc;
      mdiv_q  <= {3'b000, inc};
      mrem_q  <= '0;
      mstep_q <= '0;
      dt_q    <= $signed({1'b0, it_q.time_us}) - $signed({1'b0, o_time});
      mask_q  <= pre_mask;
    end
    if (state_q == ST_MOD) begin
      mdiv_q  <= mdiv_d;
      mrem_q  <= mrem_d;
      mstep_q <= mstep_q + 3'd1;
      if (cfg_i.modulus != 17'd0) next_q <= mrem_d;
    end
    if (state_q == ST_CHECK) begin
      finding_mask_o   <= res_mask;
      expected_count_o <= res_expc;
      interval_us_o    <= res_ivl;
    end
    if (wr_en) begin
      case (it_q.kind)
        KIND_MEAS: mmem[midx] <= it_q.quality;
        KIND_SAMPLE: begin
          lmem[lidx] <= it_q.source_mac;
          if (!it_q.reordered)
            smem[sidx] <= {it_q.smp_cnt, it_q.time_us, it_q.config_revision,
                           it_q.sync_rate_vlan, it_q.quality, it_q.dataset_tag,
                           it_q.present};
        end
        default: ;
      endcase
    end
  end

  assign idle_o = (state_q == ST_IDLE);
endmodule

// ----- hdl/sampled_value_stream_monitor.sv -----
// Sampled value stream monitor, top level: APB registers, front end, back end.
// Each item goes through the back end's read, compute, counter remainder, check and
// write-back sequence, and the back end takes the next item only after write-back.
// Two items queue in front; busy_o rises when the queue is full.
// Reset clears registers, queue and table valid bits at once; no clearing pass.
module sampled_value_stream_monitor #(
  parameter int unsigned STREAM_ENTRIES      = 64,
  parameter int unsigned LOGICAL_ENTRIES     = 64,
  parameter int unsigned MEASUREMENT_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               func_i,
  input  logic [5:0]         stream_slot_i,
  input  logic [5:0]         logical_slot_i,
  input  logic [47:0]        source_mac_i,
  input  logic [15:0]        smp_cnt_i,
  input  logic               reordered_i,
  input  logic [47:0]        time_us_i,
  input  logic [7:0]         attribute_present_i,
  input  logic [31:0]        config_revision_i,
  input  logic [35:0]        sync_rate_vlan_i,
  input  logic [31:0]        quality_i,
  input  logic [31:0]        dataset_tag_i,
  output logic               done_o,
  output logic [12:0]        finding_mask_o,
  output logic [16:0]        expected_count_o,
  output logic signed [48:0] interval_us_o
);
  import svsm_pkg::*;

  cfg_t  cfg_q;
  logic  q_valid, q_pop, fe_empty, be_idle, wr;
  item_t q_item;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        RegModulus: cfg_q.modulus <= pwdata[16:0];
        RegIval:    cfg_q.ival    <= pwdata[19:0];
        RegTol:     cfg_q.tol     <= pwdata[19:0];
        RegRate:    cfg_q.rate    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegModulus: prdata = {15'd0, cfg_q.modulus};
      RegIval:    prdata = {12'd0, cfg_q.ival};
      RegTol:     prdata = {12'd0, cfg_q.tol};
      RegRate:    prdata = {16'd0, cfg_q.rate};
      default:    prdata = '0;
    endcase
  end

  svsm_front #(
    .STREAM_ENTRIES(STREAM_ENTRIES), .LOGICAL_ENTRIES(LOGICAL_ENTRIES),
    .MEASUREMENT_ENTRIES(MEASUREMENT_ENTRIES)
  ) u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .stream_slot_i, .logical_slot_i,
    .source_mac_i, .smp_cnt_i, .reordered_i, .time_us_i, .attribute_present_i,
    .config_revision_i, .sync_rate_vlan_i, .quality_i, .dataset_tag_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop), .empty_o(fe_empty)
  );

  svsm_back #(
    .STREAM_ENTRIES(STREAM_ENTRIES), .LOGICAL_ENTRIES(LOGICAL_ENTRIES),
    .MEASUREMENT_ENTRIES(MEASUREMENT_ENTRIES)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(q_valid), .q_item_i(q_item),
    .q_pop_o(q_pop), .idle_o(be_idle), .done_o, .finding_mask_o,
    .expected_count_o, .interval_us_o
  );

  // a pop needs a queued item
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty queue");
  // results only come out of an active back end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (be_idle && fe_empty && !done_o) |=> !done_o)
    else $error("result without item");
  // a pop happens only when the back end is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> be_idle)
    else $error("pop while busy");
endmodule
